// File: hw/rtl/bsmm_pkg.sv
package bsmm_pkg;

    // Field widths fixed by the item format
    localparam int ACT_W = 3;
    localparam int IDX_W = 16;
    localparam int LEN_W = 17;
    localparam int SMP_W = 24;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MIN    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_MAX    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESIZE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_SETLEN = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CONTIG = 3'd6;

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // capture input beat
        logic clr_step;     // zero one memory word of the power-up sweep
        logic exec;         // first cycle of an item
        logic scan_issue;   // issue one memory read of a scan
        logic grow_step;    // open one more bank
        logic contig_step;  // advance bank boundary by one bank
        logic out_load;     // load result register
    } bsmm_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic             clr_last;
        logic             range_empty;
        logic             scan_done;
        logic             rd_pend;
        logic             grow_done;
        logic             contig_done;
    } bsmm_sts_t;

endpackage

// File: hw/rtl/bsmm_ctrl.sv
module bsmm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bsmm_pkg::bsmm_sts_t  sts,
    output bsmm_pkg::bsmm_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_GROW   = 3'd4;
    localparam logic [2:0] ST_CONTIG = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = in_valid && in_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (sts.action) inside
                    bsmm_pkg::ACT_READ, bsmm_pkg::ACT_MIN, bsmm_pkg::ACT_MAX:
                    begin
                        state_next = sts.range_empty ? ST_FINISH : ST_SCAN;
                    end
                    bsmm_pkg::ACT_RESIZE: state_next = ST_GROW;
                    bsmm_pkg::ACT_CONTIG: state_next = ST_CONTIG;
                    default:              state_next = ST_FINISH;
                endcase
            end
            ST_SCAN:
            begin
                cmd.scan_issue = !sts.scan_done;
                if (sts.scan_done && !sts.rd_pend)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_GROW:
            begin
                if (sts.grow_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.grow_step = 1'b1;
                end
            end
            ST_CONTIG:
            begin
                if (sts.contig_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.contig_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output beat valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The power-up sweep runs once only
    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CLEAR) |=> (state_reg != ST_CLEAR))
        else $error("sweep state re-entered");

    // An accepted beat always starts execution next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not executed");

    // A loaded result is presented
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result loaded but not valid");

endmodule

// File: hw/rtl/bsmm_dpath.sv
module bsmm_dpath #(
    parameter int BANK_SIZE = 4096,
    parameter int MAX_BANKS = 16,
    parameter int AHEAD     = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bsmm_pkg::bsmm_cmd_t                cmd,
    output bsmm_pkg::bsmm_sts_t                sts,
    input  logic        [bsmm_pkg::ACT_W-1:0]  action,
    input  logic        [bsmm_pkg::IDX_W-1:0]  index,
    input  logic        [bsmm_pkg::LEN_W-1:0]  range_end,
    input  logic        [bsmm_pkg::LEN_W-1:0]  count,
    input  logic        [bsmm_pkg::LEN_W-1:0]  new_length,
    input  logic signed [bsmm_pkg::SMP_W-1:0]  sample_in,
    output logic signed [bsmm_pkg::SMP_W-1:0]  value,
    output logic                               contiguous,
    output logic        [bsmm_pkg::LEN_W-1:0]  length_now,
    output logic        [bsmm_pkg::LEN_W-1:0]  capacity_now
);

    localparam int LEN_W     = bsmm_pkg::LEN_W;
    localparam int IDX_W     = bsmm_pkg::IDX_W;
    localparam int SMP_W     = bsmm_pkg::SMP_W;
    localparam int ACT_W     = bsmm_pkg::ACT_W;
    localparam int MEM_TOTAL = BANK_SIZE * MAX_BANKS;
    // Only the first 2^IDX_W words can ever be addressed
    localparam int MEM_WORDS = (MEM_TOTAL < (1 << IDX_W)) ? MEM_TOTAL : (1 << IDX_W);
    localparam int AW        = $clog2(MEM_WORDS);
    // Wide enough for capacity, grow target and contiguity bound
    localparam int CW        = $clog2(MEM_TOTAL + (2 << IDX_W) + BANK_SIZE + AHEAD);
    localparam int OB_W      = $clog2(MAX_BANKS + 1);
    localparam int OPEN_CEIL = (AHEAD + BANK_SIZE - 1) / BANK_SIZE;
    localparam int OPEN_RST  = (OPEN_CEIL < 1) ? 1 :
                               ((OPEN_CEIL > MAX_BANKS) ? MAX_BANKS : OPEN_CEIL);

    // Captured input beat
    logic        [ACT_W-1:0] act_reg;
    logic        [IDX_W-1:0] idx_reg;
    logic        [LEN_W-1:0] rend_reg;
    logic        [LEN_W-1:0] cnt_reg;
    logic        [LEN_W-1:0] nlen_reg;
    logic signed [SMP_W-1:0] smp_reg;

    // Architectural state
    logic        [LEN_W-1:0] valid_reg,    valid_next;
    logic        [OB_W-1:0]  open_reg,     open_next;
    logic        [CW-1:0]    cap_reg,      cap_next;
    logic signed [SMP_W-1:0] spare_reg,    spare_next;
    logic        [AW-1:0]    clr_addr_reg, clr_addr_next;

    // Working state
    logic        [LEN_W-1:0] ptr_reg,      ptr_next;
    logic        [LEN_W-1:0] end_reg,      end_next;
    logic                    rd_pend_reg,  rd_pend_next;
    logic                    rd_hit_reg,   rd_hit_next;
    logic signed [SMP_W-1:0] rd_data_reg;
    logic signed [SMP_W-1:0] best_reg,     best_next;
    logic                    first_reg,    first_next;
    logic        [CW-1:0]    target_reg,   target_next;
    logic        [CW-1:0]    bound_reg,    bound_next;

    // Result register
    logic signed [SMP_W-1:0] value_reg;
    logic                    contig_reg;
    logic        [LEN_W-1:0] len_out_reg;
    logic        [LEN_W-1:0] cap_out_reg;

    // Sample memory
    logic        [SMP_W-1:0] mem [MEM_WORDS];
    logic                    mem_we;
    logic        [AW-1:0]    mem_wa;
    logic        [SMP_W-1:0] mem_wd;

    logic        [LEN_W-1:0] idx_l;
    logic        [CW-1:0]    idx_c;
    logic        [CW-1:0]    blk_end;
    logic                    idx_hit;
    logic                    ptr_hit;
    logic        [LEN_W-1:0] lo;
    logic        [LEN_W-1:0] hi;
    logic                    is_scan;
    logic                    range_empty;
    logic signed [SMP_W-1:0] elem;
    logic                    want_max;
    logic                    take;
    logic                    fits;
    logic                    contig_val;

    assign idx_l   = LEN_W'(idx_reg);
    assign idx_c   = CW'(idx_reg);
    assign blk_end = CW'(idx_reg) + CW'(cnt_reg);
    assign idx_hit = (idx_c < cap_reg) && (idx_l < LEN_W'(MEM_WORDS));
    assign ptr_hit = (CW'(ptr_reg) < cap_reg) && (ptr_reg < LEN_W'(MEM_WORDS));

    // Scan bounds: a single read is a one-element scan with no length clamp
    assign is_scan = (act_reg == bsmm_pkg::ACT_MIN) || (act_reg == bsmm_pkg::ACT_MAX);
    always_comb
    begin
        if (is_scan)
        begin
            lo = (idx_l < valid_reg) ? idx_l : valid_reg;
            hi = (rend_reg < valid_reg) ? rend_reg : valid_reg;
        end
        else
        begin
            lo = idx_l;
            hi = idx_l + LEN_W'(1);
        end
    end
    assign range_empty = is_scan && ((valid_reg == '0) || (hi <= lo));

    // Min/max compare on the returning read
    assign elem     = rd_hit_reg ? rd_data_reg : spare_reg;
    assign want_max = (act_reg == bsmm_pkg::ACT_MAX);
    assign take     = first_reg || (want_max ? (elem > best_reg) : (elem < best_reg));

    // Contiguity: walk bank bounds until the one above the first sample
    assign fits       = (blk_end <= cap_reg);
    assign contig_val = (act_reg == bsmm_pkg::ACT_CONTIG) &&
                        ((cnt_reg == '0) || (fits && (blk_end <= bound_reg)));

    // Status
    always_comb
    begin
        sts             = '0;
        sts.action      = act_reg;
        sts.clr_last    = (clr_addr_reg == AW'(MEM_WORDS - 1));
        sts.range_empty = range_empty;
        sts.scan_done   = (ptr_reg >= end_reg);
        sts.rd_pend     = rd_pend_reg;
        sts.grow_done   = (open_reg == OB_W'(MAX_BANKS)) || (cap_reg >= target_reg);
        sts.contig_done = (cnt_reg == '0) || !fits || (idx_c < bound_reg);
    end

    // Memory write port: power-up sweep or sample write
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = clr_addr_reg;
        mem_wd = '0;
        if (cmd.clr_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.exec && (act_reg == bsmm_pkg::ACT_WRITE) && idx_hit)
        begin
            mem_we = 1'b1;
            mem_wa = idx_reg[AW-1:0];
            mem_wd = smp_reg;
        end
    end

    // Next-state logic
    always_comb
    begin
        valid_next    = valid_reg;
        open_next     = open_reg;
        cap_next      = cap_reg;
        spare_next    = spare_reg;
        clr_addr_next = clr_addr_reg;
        ptr_next      = ptr_reg;
        end_next      = end_reg;
        rd_pend_next  = 1'b0;
        rd_hit_next   = rd_hit_reg;
        best_next     = best_reg;
        first_next    = first_reg;
        target_next   = target_reg;
        bound_next    = bound_reg;

        if (cmd.clr_step)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        if (cmd.exec)
        begin
            best_next  = '0;
            first_next = 1'b1;
            ptr_next   = lo;
            end_next   = hi;
            bound_next = CW'(BANK_SIZE);
            case (act_reg)
                bsmm_pkg::ACT_WRITE:
                begin
                    if (!idx_hit)
                    begin
                        spare_next = smp_reg;
                    end
                end
                bsmm_pkg::ACT_RESIZE:
                begin
                    valid_next  = nlen_reg;
                    target_next = CW'(nlen_reg) + CW'(AHEAD);
                end
                bsmm_pkg::ACT_SETLEN:
                begin
                    valid_next = (CW'(nlen_reg) < cap_reg) ? nlen_reg : cap_reg[LEN_W-1:0];
                end
                default: ;
            endcase
        end

        // Scan: issue one read per cycle, fold it in on the cycle after
        if (cmd.scan_issue)
        begin
            ptr_next     = ptr_reg + LEN_W'(1);
            rd_pend_next = 1'b1;
            rd_hit_next  = ptr_hit;
        end
        if (rd_pend_reg)
        begin
            first_next = 1'b0;
            if (take)
            begin
                best_next = elem;
            end
        end

        // Banks open in order; a new bank holds zeros from the sweep
        if (cmd.grow_step)
        begin
            open_next = open_reg + OB_W'(1);
            cap_next  = cap_reg + CW'(BANK_SIZE);
        end

        if (cmd.contig_step)
        begin
            bound_next = bound_reg + CW'(BANK_SIZE);
        end
    end

    // Control and architectural registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            open_reg     <= OB_W'(OPEN_RST);
            cap_reg      <= CW'(OPEN_RST * BANK_SIZE);
            spare_reg    <= '0;
            clr_addr_reg <= '0;
            rd_pend_reg  <= 1'b0;
            first_reg    <= 1'b1;
        end
        else
        begin
            valid_reg    <= valid_next;
            open_reg     <= open_next;
            cap_reg      <= cap_next;
            spare_reg    <= spare_next;
            clr_addr_reg <= clr_addr_next;
            rd_pend_reg  <= rd_pend_next;
            first_reg    <= first_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= action;
            idx_reg  <= index;
            rend_reg <= range_end;
            cnt_reg  <= count;
            nlen_reg <= new_length;
            smp_reg  <= sample_in;
        end
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        rd_hit_reg <= rd_hit_next;
        best_reg   <= best_next;
        target_reg <= target_next;
        bound_reg  <= bound_next;
        if (cmd.out_load)
        begin
            value_reg   <= best_reg;
            contig_reg  <= contig_val;
            len_out_reg <= valid_reg;
            cap_out_reg <= cap_reg[LEN_W-1:0];
        end
    end

    // Sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[ptr_reg[AW-1:0]];
    end

    assign value        = value_reg;
    assign contiguous   = contig_reg;
    assign length_now   = len_out_reg;
    assign capacity_now = cap_out_reg;

    // Banks never close
    a_open_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (open_reg >= $past(open_reg)))
        else $error("open bank count decreased");

    // Length moves only on resize or clamped set
    a_len_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && ((act_reg == bsmm_pkg::ACT_RESIZE) ||
                       (act_reg == bsmm_pkg::ACT_SETLEN))) |=> $stable(valid_reg))
        else $error("length changed outside resize or set");

    // Scan never reads past its end
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> (ptr_reg < end_reg))
        else $error("scan read past range end");

endmodule

// File: hw/rtl/banked_sample_store_range_minmax_unit.sv
// Banked sample store with range min/max. One item per beat, one result beat per item.
// After reset the block sweeps the sample memory to zero, one word per cycle, over
// BANK_SIZE*MAX_BANKS words capped at 65536 (65536 with the defaults); in_ready stays
// low until the sweep ends. Items then run one at a time through a sequencer: an item
// is accepted, executed, and its result loaded into the result register before the
// next beat is accepted. Min/max issues one memory read per element on the single read
// port, then waits for the last read to return and folds it in; resize opens banks one
// at a time; contiguity walks the bank boundary up to the bank of the start index when
// the block fits in capacity with a nonzero count. The result register lets the next
// beat be accepted while a result waits; the sequencer only stalls at its last step
// if the previous result has not been taken.
module banked_sample_store_range_minmax_unit #(
    parameter int BANK_SIZE = 4096,
    parameter int MAX_BANKS = 16,
    parameter int AHEAD     = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic        [bsmm_pkg::ACT_W-1:0]  action,
    input  logic        [bsmm_pkg::IDX_W-1:0]  index,
    input  logic        [bsmm_pkg::LEN_W-1:0]  range_end,
    input  logic        [bsmm_pkg::LEN_W-1:0]  count,
    input  logic        [bsmm_pkg::LEN_W-1:0]  new_length,
    input  logic signed [bsmm_pkg::SMP_W-1:0]  sample_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [bsmm_pkg::SMP_W-1:0]  value,
    output logic                               contiguous,
    output logic        [bsmm_pkg::LEN_W-1:0]  length_now,
    output logic        [bsmm_pkg::LEN_W-1:0]  capacity_now
);

    bsmm_pkg::bsmm_cmd_t cmd;
    bsmm_pkg::bsmm_sts_t sts;

    bsmm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsmm_dpath #(
        .BANK_SIZE (BANK_SIZE),
        .MAX_BANKS (MAX_BANKS),
        .AHEAD     (AHEAD)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .index        (index),
        .range_end    (range_end),
        .count        (count),
        .new_length   (new_length),
        .sample_in    (sample_in),
        .value        (value),
        .contiguous   (contiguous),
        .length_now   (length_now),
        .capacity_now (capacity_now)
    );

endmodule

// File: test/banked_sample_store_range_minmax_unit_tb.sv
`timescale 1ns / 100ps

module banked_sample_store_range_minmax_unit_tb;

    localparam int ACT_W = bsmm_pkg::ACT_W;
    localparam int IDX_W = bsmm_pkg::IDX_W;
    localparam int LEN_W = bsmm_pkg::LEN_W;
    localparam int SMP_W = bsmm_pkg::SMP_W;

    localparam int BANK_SIZE = 4096;
    localparam int MAX_BANKS = 16;
    localparam int AHEAD     = 4096;
    localparam int MEM_DEPTH = BANK_SIZE * MAX_BANKS;

    localparam int  CLK_HALF     = 6;
    localparam int  RESET_CYCLES = 6;
    localparam int  RANDOM_ITEMS = 1525;
    localparam int  HOT_SPAN     = 256;   // window where most writes and scans land
    localparam int  DRAIN_CYCLES = 40;
    localparam int  PRINT_CAP    = 100;
    localparam longint LIMIT_NS  = 64'd4_000_000 * 2 * CLK_HALF;

    // unused action code: status only
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef struct packed {
        logic        [ACT_W-1:0] action;
        logic        [IDX_W-1:0] index;
        logic        [LEN_W-1:0] stop;
        logic        [LEN_W-1:0] count;
        logic        [LEN_W-1:0] new_length;
        logic signed [SMP_W-1:0] smp;
    } item_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] value;
        logic                    contiguous;
        logic        [LEN_W-1:0] length;
        logic        [LEN_W-1:0] capacity;
    } result_t;

    typedef struct packed {
        item_t   item;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic        [ACT_W-1:0] action;
    logic        [IDX_W-1:0] index;
    logic        [LEN_W-1:0] range_end;
    logic        [LEN_W-1:0] count;
    logic        [LEN_W-1:0] new_length;
    logic signed [SMP_W-1:0] sample_in;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [SMP_W-1:0] value;
    logic                    contiguous;
    logic        [LEN_W-1:0] length_now;
    logic        [LEN_W-1:0] capacity_now;

    // store shadow
    logic signed [SMP_W-1:0] sample_mem [0:MEM_DEPTH-1];
    logic        [LEN_W-1:0] len_q;
    int unsigned             banks_q;
    logic signed [SMP_W-1:0] spare_q;

    result_t   pending_results [$];
    stim_row_t stim_rows [$];
    int        error_count = 0;
    int        beats_sent = 0;
    int        total_beats = 0;
    int        big_scans_left = 4;
    int        src_idle_pct = 31;
    int        sink_idle_pct = 74;

    banked_sample_store_range_minmax_unit #(
        .BANK_SIZE (BANK_SIZE),
        .MAX_BANKS (MAX_BANKS),
        .AHEAD     (AHEAD)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .index        (index),
        .range_end    (range_end),
        .count        (count),
        .new_length   (new_length),
        .sample_in    (sample_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .value        (value),
        .contiguous   (contiguous),
        .length_now   (length_now),
        .capacity_now (capacity_now)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // ---------------------------------------------------------------
    // Store shadow
    // ---------------------------------------------------------------

    function automatic int unsigned store_capacity();
        return banks_q * BANK_SIZE;
    endfunction

    function automatic int unsigned banks_for(int unsigned len);
        int unsigned n;
        n = (len + AHEAD + BANK_SIZE - 1) / BANK_SIZE;
        if (n < 1)
            n = 1;
        if (n > MAX_BANKS)
            n = MAX_BANKS;
        return n;
    endfunction

    // open banks in order; a fresh bank reads as zero
    function automatic void open_banks_to(int unsigned want);
        int unsigned k;
        while (banks_q < want && banks_q < MAX_BANKS)
        begin
            for (k = 0; k < BANK_SIZE; k++)
                sample_mem[banks_q * BANK_SIZE + k] = '0;
            banks_q++;
        end
    endfunction

    // beyond capacity everything hits the spare word
    function automatic logic signed [SMP_W-1:0] sample_at(int unsigned addr);
        if (addr < store_capacity() && addr < MEM_DEPTH)
            return sample_mem[addr];
        return spare_q;
    endfunction

    function automatic void clear_store();
        int unsigned k;
        for (k = 0; k < MEM_DEPTH; k++)
            sample_mem[k] = '0;
        len_q   = '0;
        banks_q = 0;
        spare_q = '0;
        open_banks_to(banks_for(0));
    endfunction

    // apply one beat to the shadow and return the status it reports
    function automatic result_t store_step(item_t it);
        result_t                 r;
        int unsigned             cap;
        int unsigned             first;
        int unsigned             last;
        int unsigned             i;
        int unsigned             idx;
        int unsigned             cnt;
        logic signed [SMP_W-1:0] best;
        logic signed [SMP_W-1:0] v;
        r   = '0;
        cap = store_capacity();
        idx = it.index;
        cnt = it.count;
        case (it.action) inside
            bsmm_pkg::ACT_WRITE:
            begin
                if (idx < cap)
                    sample_mem[idx] = it.smp;
                else
                    spare_q = it.smp;
            end
            bsmm_pkg::ACT_READ:
                r.value = sample_at(idx);
            bsmm_pkg::ACT_MIN, bsmm_pkg::ACT_MAX:
            begin
                // range clamped to the valid length; empty or inverted gives zero
                first = (idx < len_q) ? idx : len_q;
                last  = (it.stop < len_q) ? it.stop : len_q;
                if (len_q != 0 && last > first)
                begin
                    best = sample_at(first);
                    for (i = first + 1; i < last; i++)
                    begin
                        v = sample_at(i);
                        if (it.action == bsmm_pkg::ACT_MAX ? (v > best) : (v < best))
                            best = v;
                    end
                    r.value = best;
                end
            end
            bsmm_pkg::ACT_RESIZE:
            begin
                len_q = it.new_length;
                open_banks_to(banks_for(len_q));
            end
            bsmm_pkg::ACT_SETLEN:
                len_q = (it.new_length < cap) ? it.new_length : LEN_W'(cap);
            bsmm_pkg::ACT_CONTIG:
            begin
                if (cnt == 0)
                    r.contiguous = 1'b1;
                else if (idx + cnt > cap)
                    r.contiguous = 1'b0;
                else
                    r.contiguous = (idx / BANK_SIZE == (idx + cnt - 1) / BANK_SIZE);
            end
            default:
                ;
        endcase
        r.length   = len_q;
        r.capacity = LEN_W'(store_capacity());
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    task automatic add_row(input int act, input int idx, input int stop, input int cnt,
                           input int nlen, input int smp, input bit typed, input int val,
                           input int contig, input int len, input int cap);
        stim_row_t r;
        r.item.action     = ACT_W'(act);
        r.item.index      = IDX_W'(idx);
        r.item.stop       = LEN_W'(stop);
        r.item.count      = LEN_W'(cnt);
        r.item.new_length = LEN_W'(nlen);
        r.item.smp        = SMP_W'(smp);
        r.typed           = typed;
        r.want.value      = SMP_W'(val);
        r.want.contiguous = contig[0];
        r.want.length     = LEN_W'(len);
        r.want.capacity   = LEN_W'(cap);
        stim_rows.push_back(r);
    endtask

    // mostly the hot window, some within capacity, some anywhere (spare hits)
    function automatic logic [IDX_W-1:0] pick_index(int unsigned cap);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return IDX_W'($urandom_range(0, HOT_SPAN - 1));
        if (sel < 8)
            return IDX_W'($urandom_range(0, cap - 1));
        return IDX_W'($urandom_range(0, 65535));
    endfunction

    function automatic item_t random_item();
        item_t       it;
        int unsigned cap;
        int unsigned len;
        int unsigned pick;
        int unsigned sel;
        int unsigned start;
        int unsigned stop;
        cap = store_capacity();
        len = len_q;
        // noise in every field, then shape what the action uses
        it.action     = '0;
        it.index      = IDX_W'($urandom);
        it.stop       = LEN_W'($urandom_range(0, 65536));
        it.count      = LEN_W'($urandom_range(0, 65536));
        it.new_length = LEN_W'($urandom_range(0, 65536));
        it.smp        = SMP_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            it.action = bsmm_pkg::ACT_WRITE;
            it.index  = pick_index(cap);
        end
        else if (pick < 42)
        begin
            it.action = bsmm_pkg::ACT_READ;
            it.index  = pick_index(cap);
        end
        else if (pick < 70)
        begin
            it.action = ($urandom_range(0, 1) != 0) ? bsmm_pkg::ACT_MAX : bsmm_pkg::ACT_MIN;
            sel = $urandom_range(0, 99);
            if (sel < 60)
            begin
                start = $urandom_range(0, HOT_SPAN - 1);
                stop  = start + $urandom_range(0, 40);
            end
            else if (sel < 75)
            begin
                start = $urandom_range(0, 65535);
                stop  = start + $urandom_range(0, 40);
            end
            else if (sel < 85)
            begin
                // inverted
                start = $urandom_range(0, 65535);
                stop  = $urandom_range(0, start);
            end
            else if (sel < 99)
            begin
                // near the end of the valid length, end often past it
                start = len - $urandom_range(0, (len < 30) ? len : 30);
                if ($urandom_range(0, 3) == 0)
                    start = len + $urandom_range(0, 8);
                stop = $urandom_range(len, 65536);
            end
            else if (big_scans_left > 0)
            begin
                big_scans_left--;
                start = 0;
                stop  = 65536;
            end
            else
            begin
                start = 0;
                stop  = 0;
            end
            if (start > 65535)
                start = 65535;
            if (stop > 65536)
                stop = 65536;
            it.index = IDX_W'(start);
            it.stop  = LEN_W'(stop);
        end
        else if (pick < 75)
        begin
            it.action = bsmm_pkg::ACT_RESIZE;
            // usually opens at most one more bank, so capacity grows slowly
            if ($urandom_range(0, 9) != 0)
                it.new_length = LEN_W'($urandom_range(0, cap));
        end
        else if (pick < 82)
        begin
            it.action = bsmm_pkg::ACT_SETLEN;
            sel = $urandom_range(0, 9);
            if (sel < 5)
                it.new_length = LEN_W'($urandom_range(0, cap));
            else if (sel < 8)
                it.new_length = LEN_W'($urandom_range(0, 300));
        end
        else if (pick < 96)
        begin
            it.action = bsmm_pkg::ACT_CONTIG;
            sel = $urandom_range(0, 9);
            if (sel < 2)
                it.count = '0;
            else if (sel < 5)
                it.count = LEN_W'($urandom_range(1, 64));
            else if (sel < 8)
            begin
                // straddle or just touch a bank boundary
                start    = $urandom_range(1, MAX_BANKS) * BANK_SIZE - $urandom_range(1, 8);
                it.index = IDX_W'(start);
                it.count = LEN_W'($urandom_range(1, 16));
            end
            else if (sel < 9)
                it.count = LEN_W'(65536);
        end
        else
            it.action = ACT_UNUSED;
        return it;
    endfunction

    // one input beat: optional gap, hold until accepted, then predict
    task automatic send_beat(input item_t it, input bit typed, input result_t want);
        result_t got;
        if (beats_sent < total_beats / 3)
        begin
            src_idle_pct  = 31;
            sink_idle_pct = 74;
        end
        else if (beats_sent < 2 * total_beats / 3)
        begin
            src_idle_pct  = 74;
            sink_idle_pct = 31;
        end
        else
        begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        action     <= it.action;
        index      <= it.index;
        range_end  <= it.stop;
        count      <= it.count;
        new_length <= it.new_length;
        sample_in  <= it.smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = store_step(it);
        pending_results.push_back(typed ? want : got);
        beats_sent++;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t ns: MISMATCH %s", $time, msg);
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    // check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending");
            else
            begin
                exp_r = pending_results.pop_front();
                if (value !== exp_r.value)
                    report_mismatch($sformatf("value %0d, want %0d",
                                              value, exp_r.value));
                if (contiguous !== exp_r.contiguous)
                    report_mismatch($sformatf("contiguous %b, want %b",
                                              contiguous, exp_r.contiguous));
                if (length_now !== exp_r.length)
                    report_mismatch($sformatf("length_now %0d, want %0d",
                                              length_now, exp_r.length));
                if (capacity_now !== exp_r.capacity)
                    report_mismatch($sformatf("capacity_now %0d, want %0d",
                                              capacity_now, exp_r.capacity));
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------

    initial
    begin
        int    n;
        item_t it;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = '0;
        index      = '0;
        range_end  = '0;
        count      = '0;
        new_length = '0;
        sample_in  = '0;
        out_ready  = 1'b0;
        clear_store();

        // directed rows; fields: action, index, end, count, new length, sample,
        // then the typed status where it is obvious
        // fresh store: one bank open, length zero
        add_row(bsmm_pkg::ACT_READ, 0, 0, 0, 0, 0, TYPED, 0, 0, 0, 4096);
        add_row(bsmm_pkg::ACT_MIN, 0, 65536, 0, 0, 0, TYPED, 0, 0, 0, 4096);
        // full-scale samples
        add_row(bsmm_pkg::ACT_WRITE, 0, 0, 0, 0, 'h7FFFFF, TYPED, 0, 0, 0, 4096);
        add_row(bsmm_pkg::ACT_WRITE, 1, 0, 0, 0, 'h800000, TYPED, 0, 0, 0, 4096);
        // spare word beyond capacity
        add_row(bsmm_pkg::ACT_WRITE, 65535, 0, 0, 0, 'h123456, TYPED, 0, 0, 0, 4096);
        add_row(bsmm_pkg::ACT_READ, 65535, 0, 0, 0, 0, TYPED, 'h123456, 0, 0, 4096);
        add_row(bsmm_pkg::ACT_READ, 4096, 0, 0, 0, 0, TYPED, 'h123456, 0, 0, 4096);
        // set length clamps at capacity
        add_row(bsmm_pkg::ACT_SETLEN, 0, 0, 0, 65536, 0, TYPED, 0, 0, 4096, 4096);
        add_row(bsmm_pkg::ACT_MAX, 0, 4, 0, 0, 0, TYPED, 'h7FFFFF, 0, 4096, 4096);
        add_row(bsmm_pkg::ACT_MIN, 0, 4, 0, 0, 0, TYPED, 'h800000, 0, 4096, 4096);
        // inverted and empty ranges
        add_row(bsmm_pkg::ACT_MIN, 3, 2, 0, 0, 0, TYPED, 0, 0, 4096, 4096);
        add_row(bsmm_pkg::ACT_MAX, 2, 2, 0, 0, 0, TYPED, 0, 0, 4096, 4096);
        // contiguity: zero count, past capacity, whole bank
        add_row(bsmm_pkg::ACT_CONTIG, 0, 0, 0, 0, 0, TYPED, 0, 1, 4096, 4096);
        add_row(bsmm_pkg::ACT_CONTIG, 4095, 0, 2, 0, 0, TYPED, 0, 0, 4096, 4096);
        add_row(bsmm_pkg::ACT_CONTIG, 0, 0, 4096, 0, 0, TYPED, 0, 1, 4096, 4096);
        // resize opens two more banks
        add_row(bsmm_pkg::ACT_RESIZE, 0, 0, 0, 4097, 0, TYPED, 0, 0, 4097, 12288);
        add_row(bsmm_pkg::ACT_CONTIG, 4095, 0, 2, 0, 0, TYPED, 0, 0, 4097, 12288);
        add_row(bsmm_pkg::ACT_CONTIG, 65535, 0, 65536, 0, 0, TYPED, 0, 0, 4097, 12288);
        add_row(bsmm_pkg::ACT_READ, 8192, 0, 0, 0, 0, TYPED, 0, 0, 4097, 12288);
        add_row(ACT_UNUSED, 0, 0, 0, 0, 0, TYPED, 0, 0, 4097, 12288);
        add_row(bsmm_pkg::ACT_MAX, 0, 65536, 0, 0, 0, TYPED, 'h7FFFFF, 0, 4097, 12288);
        add_row(bsmm_pkg::ACT_WRITE, 12288, 0, 0, 0, 1, TYPED, 0, 0, 4097, 12288);
        add_row(bsmm_pkg::ACT_READ, 65535, 0, 0, 0, 0, TYPED, 1, 0, 4097, 12288);
        // shrinking resize keeps banks open
        add_row(bsmm_pkg::ACT_RESIZE, 0, 0, 0, 0, 0, TYPED, 0, 0, 0, 12288);
        add_row(bsmm_pkg::ACT_SETLEN, 0, 0, 0, 5, 0, PREDICTED, 0, 0, 0, 0);
        add_row(bsmm_pkg::ACT_MIN, 0, 5, 0, 0, 0, PREDICTED, 0, 0, 0, 0);

        total_beats = stim_rows.size() + RANDOM_ITEMS;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[k])
            send_beat(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            it = random_item();
            send_beat(it, PREDICTED, '0);
        end
        in_valid <= 1'b0;

        // drain, then watch for stray beats
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("banked_sample_store_range_minmax_unit_tb: clean");
        else
            $display("banked_sample_store_range_minmax_unit_tb: errors");
        $finish;
    end

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("banked_sample_store_range_minmax_unit_tb: errors");
        $finish;
    end

endmodule
